// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is held.
`define AST_ON(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define AST_ALL(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/core/brg_pkg.sv =====
package brg_pkg;

  // Record layout
  localparam logic [8:0] SIG_END    = 9'd14;
  localparam logic [8:0] HDR_BASE   = 9'd256;
  localparam logic [8:0] HASH_FIRST = 9'd280;
  localparam logic [8:0] HASH_LAST  = 9'd311;
  localparam logic [8:0] CRC_AT     = 9'd440;
  localparam logic [8:0] CRC_END    = 9'd444;
  localparam logic [8:0] LAST_OFF   = 9'd511;

  localparam logic [7:0]  FILL_BYTE    = 8'hFF;
  localparam logic [31:0] MAGIC_WORD   = 32'h0052424D;
  localparam logic [31:0] HDR_LEN_WORD = 32'h000000B4;
  localparam logic [31:0] VERSION_WORD = 32'h00000000;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

  // Header word slots, counted from the header base
  localparam logic [2:0] W_MAGIC = 3'd0;
  localparam logic [2:0] W_LEN   = 3'd1;
  localparam logic [2:0] W_VER   = 3'd2;
  localparam logic [2:0] W_EXEC  = 3'd3;
  localparam logic [2:0] W_STORE = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_EXEC  = 2'd0;
  localparam logic [1:0] REG_STORE = 2'd1;
  localparam logic [1:0] REG_LEN   = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  // One classified record byte, handed from front to back
  typedef struct packed {
    logic [8:0] offset;
    logic [7:0] data;
    logic       crc_upd;
    logic       crc_emit;
    logic       last;
  } cmd_t;

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0: b = w[7:0];
      2'd1: b = w[15:8];
      2'd2: b = w[23:16];
      default: b = w[31:24];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [3:0] i);
    logic [7:0] b;
    unique case (i)
      4'd0:  b = 8'h43;
      4'd1:  b = 8'h46;
      4'd2:  b = 8'h47;
      4'd3:  b = 8'h00;
      4'd4:  b = 8'h04;
      4'd5:  b = 8'h02;
      4'd6:  b = 8'h02;
      4'd7:  b = 8'h00;
      4'd8:  b = 8'h00;
      4'd9:  b = 8'h00;
      4'd10: b = 8'hAE;
      4'd11: b = 8'h43;
      4'd12: b = 8'h70;
      4'd13: b = 8'hAC;
      default: b = FILL_BYTE;
    endcase
    return b;
  endfunction

  // Reflected CRC-32 update by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = {24'd0, b ^ crc[7:0]};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
    end
    return v ^ (crc >> 8);
  endfunction

endpackage

// ===== rtl/core/brg_front.sv =====
module brg_front
  import brg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  hash_byte,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [8:0]  position_r, position_nxt;
  logic [31:0] exec_address_r, store_address_r, image_length_r;
  logic [31:0] hdr_word;
  logic [8:0]  off;

  assign off      = position_r;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Advance the position on every accepted transfer, wrap after the last byte
  always_comb begin
    position_nxt = position_r;
    if (q_push) begin
      position_nxt = (off == LAST_OFF) ? 9'd0 : off + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= 9'd0;
    end else begin
      position_r <= position_nxt;
    end
  end

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_address_r  <= 32'd0;
      store_address_r <= 32'd0;
      image_length_r  <= 32'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_EXEC) begin
        exec_address_r <= cfg_data;
      end
      if (cfg_index == REG_STORE) begin
        store_address_r <= cfg_data;
      end
      if (cfg_index == REG_LEN) begin
        image_length_r <= cfg_data;
      end
    end
  end

  // Select the header word for the current slot
  always_comb begin
    unique case (off[4:2])
      W_MAGIC: hdr_word = MAGIC_WORD;
      W_LEN:   hdr_word = HDR_LEN_WORD;
      W_VER:   hdr_word = VERSION_WORD;
      W_EXEC:  hdr_word = exec_address_r;
      W_STORE: hdr_word = store_address_r;
      default: hdr_word = image_length_r;
    endcase
  end

  // Classify the current offset
  always_comb begin
    q_cmd.offset   = off;
    q_cmd.data     = FILL_BYTE;
    q_cmd.crc_upd  = (off >= HDR_BASE) && (off < CRC_AT);
    q_cmd.crc_emit = 1'b0;
    q_cmd.last     = (off == LAST_OFF);
    priority if (off < SIG_END) begin
      q_cmd.data = sig_byte(off[3:0]);
    end else if (off < HDR_BASE) begin
      q_cmd.data = FILL_BYTE;
    end else if (off < HASH_FIRST) begin
      q_cmd.data = word_byte(hdr_word, off[1:0]);
    end else if (off <= HASH_LAST) begin
      q_cmd.data = hash_byte;
    end else if (off < CRC_AT) begin
      q_cmd.data = FILL_BYTE;
    end else if (off < CRC_END) begin
      q_cmd.crc_emit = 1'b1;
    end else begin
      q_cmd.data = FILL_BYTE;
    end
  end

endmodule

// ===== rtl/core/brg_queue.sv =====
module brg_queue
  import brg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/brg_back.sv =====
module brg_back
  import brg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [8:0] byte_offset,
  output logic       last_byte
);

  logic [31:0] running_crc_r, running_crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic [8:0]  byte_offset_r;
  logic        last_byte_r;
  logic [7:0]  cur_byte;

  assign q_pop       = q_valid && (!out_valid_r || out_ready);
  assign cur_byte    = q_head.crc_emit ? word_byte(running_crc_r, q_head.offset[1:0])
                                       : q_head.data;
  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign byte_offset = byte_offset_r;
  assign last_byte   = last_byte_r;

  // Fold CRC-covered bytes into the CRC, restart it at the end of a record, and track output valid
  always_comb begin
    running_crc_nxt = running_crc_r;
    out_valid_nxt   = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      if (q_head.last) begin
        running_crc_nxt = CRC_INIT;
      end else if (q_head.crc_upd) begin
        running_crc_nxt = crc_byte(running_crc_r, cur_byte);
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= CRC_INIT;
      out_valid_r   <= 1'b0;
    end else begin
      running_crc_r <= running_crc_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_byte_r    <= cur_byte;
      byte_offset_r <= q_head.offset;
      last_byte_r   <= q_head.last;
    end
  end

endmodule

// ===== rtl/core/boot_record_generator_crc32.sv =====
// Path: an accepted byte is written into the queue, then popped into the output register
// once that register is empty or its byte is being taken by the output side.
// Throughput: one byte per cycle, sustained, while the output side keeps taking.
// The pace is set by the one-byte CRC update ahead of the output register.
// Reset: position 0, CRC all ones, configuration words 0, queue and output empty.
module boot_record_generator_crc32
  import brg_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] hash_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [16:8] byte_offset, [23:17] zero
  output logic        out_tlast,  // last_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t       push_cmd, head_cmd;
  logic       q_push, q_full, q_pop, q_valid;
  logic [7:0] out_byte;
  logic [8:0] byte_offset;

  assign cfg_ready = 1'b1;
  assign out_tdata = {7'd0, byte_offset, out_byte};

  brg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .hash_byte (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  brg_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  brg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_byte),
    .byte_offset (byte_offset),
    .last_byte   (out_tlast)
  );

endmodule

// ===== rtl/core/brg_checker.sv =====
`include "assert_macros.svh"

module brg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // A stalled output transfer keeps its payload
  `AST_ON(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // Nothing is offered right after reset
  `AST_ALL(a_rst_empty, !rst_n |=> !out_tvalid)

  // The last flag marks the final record offset only
  `AST_ON(a_last_off, out_tvalid |-> (out_tlast == (out_tdata[16:8] == 9'd511)))

  // Padding bits above the offset stay zero
  `AST_ON(a_pad_zero, out_tvalid |-> out_tdata[23:17] == 7'd0)

endmodule

bind boot_record_generator_crc32 brg_checker u_brg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
